>>> sv/assert_macros.svh
// assertion helpers, sampled on clk, off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define RSC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define RSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/rsc_pkg.sv
`timescale 1ns / 1ps

package rsc_pkg;

  localparam int STACK_DEPTH_DEF = 128;

  localparam logic [3:0] OP_PUSH  = 4'd0;
  localparam logic [3:0] OP_ADD   = 4'd1;
  localparam logic [3:0] OP_SUB   = 4'd2;
  localparam logic [3:0] OP_MUL   = 4'd3;
  localparam logic [3:0] OP_DIV   = 4'd4;
  localparam logic [3:0] OP_PEEK  = 4'd5;
  localparam logic [3:0] OP_DUP   = 4'd6;
  localparam logic [3:0] OP_SWAP  = 4'd7;
  localparam logic [3:0] OP_CLEAR = 4'd8;
  localparam logic [3:0] OP_POP   = 4'd9;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_FULL  = 3'd2;
  localparam logic [2:0] ST_ZDIV  = 3'd3;
  localparam logic [2:0] ST_SWAP  = 3'd4;

  typedef enum logic [1:0] {
    AK_ADD = 2'd0,
    AK_SUB = 2'd1,
    AK_MUL = 2'd2,
    AK_DIV = 2'd3
  } arith_kind_t;

  typedef struct packed {
    logic        start;
    arith_kind_t kind;
    logic [31:0] a;
    logic [31:0] b;
  } arith_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } arith_rsp_t;

endpackage

>>> sv/rpn_stack_calculator_core.sv
// from accept to result register: push, clear and unused codes go straight to S_DONE;
// peek, pop and dup pass S_RD1 and S_RD2; swap adds S_SWAP, arithmetic that runs adds S_ARITH
// div time is set by the shared divider, one quotient bit per cycle over 33 bits
// one transaction in flight; the next is taken the cycle after its result is registered
// synchronous active-low reset empties the stack and drops any held result
`timescale 1ns / 1ps

module rpn_stack_calculator_core #(
  parameter int STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_op,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_result_value,
  output logic               out_shown,
  output logic [2:0]         out_status,
  output logic [7:0]         out_depth_after
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RD1   = 6'b000010,
    S_RD2   = 6'b000100,
    S_ARITH = 6'b001000,
    S_SWAP  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t      state_r, state_nxt;
  logic [3:0]  op_r, op_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [31:0] b_r, b_nxt;
  logic [2:0]  status_r, status_nxt;
  logic        shown_r, shown_nxt;
  logic [31:0] res_r, res_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_res_r, out_res_nxt;
  logic        out_shown_r, out_shown_nxt;
  logic [2:0]  out_status_r, out_status_nxt;
  logic [7:0]  out_depth_r, out_depth_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [31:0]   mem_rdata;

  rsc_pkg::arith_req_t arith_req;
  rsc_pkg::arith_rsp_t arith_rsp;

  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] cnt_m2;
  logic [CW-1:0] cnt_p1;
  logic          has1;
  logic          has2;
  logic          full;
  logic [31:0]   a_val;
  logic [CW+7:0] cnt_ext;
  logic          accept;

  assign cnt_m1  = cnt_r - CW'(1);
  assign cnt_m2  = cnt_r - CW'(2);
  assign cnt_p1  = cnt_r + CW'(1);
  assign has1    = cnt_r != '0;
  assign has2    = cnt_r >= CW'(2);
  assign full    = cnt_r == DEPTH_C;
  assign a_val   = has2 ? mem_rdata : 32'd0;
  assign cnt_ext = {8'd0, cnt_r};
  assign in_stall = !rst_n || (state_r != S_IDLE);
  assign accept  = in_valid && !in_stall;

  rsc_stack_mem #(
    .DEPTH (STACK_DEPTH)
  ) u_stack_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rsc_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (arith_req),
    .rsp   (arith_rsp)
  );

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    cnt_nxt        = cnt_r;
    b_nxt          = b_r;
    status_nxt     = status_r;
    shown_nxt      = shown_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_res_nxt    = out_res_r;
    out_shown_nxt  = out_shown_r;
    out_status_nxt = out_status_r;
    out_depth_nxt  = out_depth_r;
    mem_we         = 1'b0;
    mem_waddr      = cnt_r[AW-1:0];
    mem_wdata      = b_r;
    mem_raddr      = cnt_m1[AW-1:0];
    arith_req.start = 1'b0;
    arith_req.kind  = rsc_pkg::AK_ADD;
    arith_req.a     = a_val;
    arith_req.b     = b_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt     = in_op;
          status_nxt = rsc_pkg::ST_OK;
          shown_nxt  = 1'b0;
          res_nxt    = 32'd0;
          case (in_op)
            rsc_pkg::OP_PUSH: begin
              if (!full) begin
                mem_we    = 1'b1;
                mem_wdata = in_value;
                cnt_nxt   = cnt_p1;
              end else begin
                status_nxt = rsc_pkg::ST_FULL;
              end
              state_nxt = S_DONE;
            end
            rsc_pkg::OP_CLEAR: begin
              cnt_nxt   = '0;
              state_nxt = S_DONE;
            end
            rsc_pkg::OP_ADD, rsc_pkg::OP_SUB, rsc_pkg::OP_MUL, rsc_pkg::OP_DIV,
            rsc_pkg::OP_PEEK, rsc_pkg::OP_DUP, rsc_pkg::OP_SWAP, rsc_pkg::OP_POP: begin
              state_nxt = S_RD1;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_RD1: begin
        b_nxt     = has1 ? mem_rdata : 32'd0;
        mem_raddr = cnt_m2[AW-1:0];
        state_nxt = S_RD2;
      end
      S_RD2: begin
        state_nxt = S_DONE;
        case (op_r)
          rsc_pkg::OP_PEEK: begin
            if (has1) begin
              shown_nxt = 1'b1;
              res_nxt   = b_r;
            end else begin
              status_nxt = rsc_pkg::ST_EMPTY;
            end
          end
          rsc_pkg::OP_POP: begin
            shown_nxt = 1'b1;
            res_nxt   = b_r;
            if (has1) begin
              cnt_nxt = cnt_m1;
            end else begin
              status_nxt = rsc_pkg::ST_EMPTY;
            end
          end
          rsc_pkg::OP_DUP: begin
            if (!has1) begin
              status_nxt = rsc_pkg::ST_EMPTY;
            end else if (full) begin
              status_nxt = rsc_pkg::ST_FULL;
            end else begin
              mem_we  = 1'b1;
              cnt_nxt = cnt_p1;
            end
          end
          rsc_pkg::OP_SWAP: begin
            if (!has2) begin
              status_nxt = rsc_pkg::ST_SWAP;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = cnt_m1[AW-1:0];
              mem_wdata = a_val;
              state_nxt = S_SWAP;
            end
          end
          rsc_pkg::OP_DIV: begin
            if (!has1) begin
              status_nxt = rsc_pkg::ST_EMPTY;
            end else if (b_r == 32'd0) begin
              status_nxt = rsc_pkg::ST_ZDIV;
              cnt_nxt    = cnt_m1;
            end else begin
              arith_req.start = 1'b1;
              arith_req.kind  = rsc_pkg::AK_DIV;
              status_nxt      = has2 ? rsc_pkg::ST_OK : rsc_pkg::ST_EMPTY;
              state_nxt       = S_ARITH;
            end
          end
          rsc_pkg::OP_ADD, rsc_pkg::OP_SUB, rsc_pkg::OP_MUL: begin
            arith_req.start = 1'b1;
            if (op_r == rsc_pkg::OP_ADD) begin
              arith_req.kind = rsc_pkg::AK_ADD;
            end else if (op_r == rsc_pkg::OP_SUB) begin
              arith_req.kind = rsc_pkg::AK_SUB;
            end else begin
              arith_req.kind = rsc_pkg::AK_MUL;
            end
            status_nxt = has2 ? rsc_pkg::ST_OK : rsc_pkg::ST_EMPTY;
            state_nxt  = S_ARITH;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_SWAP: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_m2[AW-1:0];
        state_nxt = S_DONE;
      end
      S_ARITH: begin
        if (arith_rsp.done) begin
          mem_we    = 1'b1;
          mem_waddr = has2 ? cnt_m2[AW-1:0] : '0;
          mem_wdata = arith_rsp.result;
          cnt_nxt   = has2 ? cnt_m1 : CW'(1);
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_res_nxt    = res_r;
          out_shown_nxt  = shown_r;
          out_status_nxt = status_r;
          out_depth_nxt  = cnt_ext[7:0];
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    b_r          <= b_nxt;
    status_r     <= status_nxt;
    shown_r      <= shown_nxt;
    res_r        <= res_nxt;
    out_res_r    <= out_res_nxt;
    out_shown_r  <= out_shown_nxt;
    out_status_r <= out_status_nxt;
    out_depth_r  <= out_depth_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_res_r;
  assign out_shown        = out_shown_r;
  assign out_status       = out_status_r;
  assign out_depth_after  = out_depth_r;

endmodule

>>> sv/rsc_stack_mem.sv
`timescale 1ns / 1ps

module rsc_stack_mem #(
  parameter int DEPTH = rsc_pkg::STACK_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [31:0]              wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [31:0]              rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/rsc_arith.sv
`timescale 1ns / 1ps

module rsc_arith (
  input  logic                clk,
  input  logic                rst_n,
  input  rsc_pkg::arith_req_t req,
  output rsc_pkg::arith_rsp_t rsp
);

  localparam logic [5:0] DIV_STEPS = 6'd33;

  typedef enum logic [4:0] {
    A_IDLE = 5'b00001,
    A_PREP = 5'b00010,
    A_MUL  = 5'b00100,
    A_DIV  = 5'b01000,
    A_FIN  = 5'b10000
  } astate_t;

  astate_t              st_r, st_nxt;
  rsc_pkg::arith_kind_t kind_r, kind_nxt;
  logic [31:0]          opa_r, opa_nxt;
  logic [31:0]          opb_r, opb_nxt;
  logic [31:0]          ma_r, ma_nxt;
  logic [31:0]          mb_r, mb_nxt;
  logic                 neg_r, neg_nxt;
  logic [47:0]          q_r, q_nxt;
  logic [31:0]          rem_r, rem_nxt;
  logic [32:0]          dsh_r, dsh_nxt;
  logic [5:0]           step_r, step_nxt;
  logic                 done_r, done_nxt;
  logic [31:0]          result_r, result_nxt;

  logic [31:0] ma_c;
  logic [31:0] mb_c;
  logic [32:0] sum_c;
  logic [31:0] sum_sat;
  logic [63:0] prod_c;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;
  logic        big;
  logic [31:0] fin_res;

  assign ma_c   = opa_r[31] ? (~opa_r + 32'd1) : opa_r;
  assign mb_c   = opb_r[31] ? (~opb_r + 32'd1) : opb_r;
  assign sum_c  = (kind_r == rsc_pkg::AK_SUB) ? ({opa_r[31], opa_r} - {opb_r[31], opb_r})
                                              : ({opa_r[31], opa_r} + {opb_r[31], opb_r});
  assign sum_sat = (sum_c[32] != sum_c[31]) ? (sum_c[32] ? 32'h8000_0000 : 32'h7fff_ffff)
                                            : sum_c[31:0];
  assign prod_c = ma_r * mb_r;
  assign trial  = {rem_r, dsh_r[32]};
  assign diff   = trial - {1'b0, mb_r};
  assign ge     = trial >= {1'b0, mb_r};
  assign big    = |q_r[47:31];

  always_comb begin
    if (neg_r) begin
      fin_res = big ? 32'h8000_0000 : (~q_r[31:0] + 32'd1);
    end else begin
      fin_res = big ? 32'h7fff_ffff : q_r[31:0];
    end
  end

  always_comb begin
    st_nxt     = st_r;
    kind_nxt   = kind_r;
    opa_nxt    = opa_r;
    opb_nxt    = opb_r;
    ma_nxt     = ma_r;
    mb_nxt     = mb_r;
    neg_nxt    = neg_r;
    q_nxt      = q_r;
    rem_nxt    = rem_r;
    dsh_nxt    = dsh_r;
    step_nxt   = step_r;
    done_nxt   = 1'b0;
    result_nxt = result_r;
    case (st_r)
      A_IDLE: begin
        if (req.start) begin
          kind_nxt = req.kind;
          opa_nxt  = req.a;
          opb_nxt  = req.b;
          st_nxt   = A_PREP;
        end
      end
      A_PREP: begin
        ma_nxt  = ma_c;
        mb_nxt  = mb_c;
        neg_nxt = opa_r[31] != opb_r[31];
        case (kind_r)
          rsc_pkg::AK_ADD, rsc_pkg::AK_SUB: begin
            result_nxt = sum_sat;
            done_nxt   = 1'b1;
            st_nxt     = A_IDLE;
          end
          rsc_pkg::AK_MUL: begin
            st_nxt = A_MUL;
          end
          default: begin
            rem_nxt  = {17'd0, ma_c[31:17]};
            dsh_nxt  = {ma_c[16:0], 16'd0};
            step_nxt = DIV_STEPS;
            if ({17'd0, ma_c[31:17]} >= mb_c) begin
              q_nxt  = '1;
              st_nxt = A_FIN;
            end else begin
              q_nxt  = '0;
              st_nxt = A_DIV;
            end
          end
        endcase
      end
      A_MUL: begin
        q_nxt  = prod_c[63:16];
        st_nxt = A_FIN;
      end
      A_DIV: begin
        q_nxt    = {q_r[46:0], ge};
        rem_nxt  = ge ? diff[31:0] : trial[31:0];
        dsh_nxt  = {dsh_r[31:0], 1'b0};
        step_nxt = step_r - 6'd1;
        if (step_r == 6'd1) begin
          st_nxt = A_FIN;
        end
      end
      A_FIN: begin
        result_nxt = fin_res;
        done_nxt   = 1'b1;
        st_nxt     = A_IDLE;
      end
      default: begin
        st_nxt = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= A_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    kind_r   <= kind_nxt;
    opa_r    <= opa_nxt;
    opb_r    <= opb_nxt;
    ma_r     <= ma_nxt;
    mb_r     <= mb_nxt;
    neg_r    <= neg_nxt;
    q_r      <= q_nxt;
    rem_r    <= rem_nxt;
    dsh_r    <= dsh_nxt;
    step_r   <= step_nxt;
    result_r <= result_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = result_r;

endmodule

>>> sv/rsc_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rsc_props (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_result_value,
  input logic               out_shown,
  input logic [2:0]         out_status,
  input logic [7:0]         out_depth_after
);

  // held result stays put
  `RSC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_result_value) && $stable(out_status) && $stable(out_depth_after), "stalled result changed")

  // one transaction at a time on the input side
  `RSC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input taken while busy")

  `RSC_ASSERT_IMP(a_quiet_value, out_valid && !out_shown, out_result_value == 32'sd0, "value without show")

  `RSC_ASSERT_IMP(a_shown_status, out_valid && out_shown, out_status == rsc_pkg::ST_OK || out_status == rsc_pkg::ST_EMPTY, "shown with bad status")

  `RSC_ASSERT_IMP(a_swap_depth, out_valid && out_status == rsc_pkg::ST_SWAP, !out_shown && out_depth_after <= 8'd1, "swap error with deep stack")

endmodule

bind rpn_stack_calculator_core rsc_props u_rsc_props (.*);

>>> tb/sv/rsc_checker.sv
`timescale 1ns / 1ps

module rsc_checker #(
  parameter int STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [3:0]         in_op,
  input  logic signed [31:0] in_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_result_value,
  input  logic               out_shown,
  input  logic [2:0]         out_status,
  input  logic [7:0]         out_depth_after,
  output int                 n_errors,
  output int                 n_pending
);

  typedef struct packed {
    logic signed [31:0] value;
    logic               shown;
    logic [2:0]         status;
    logic [7:0]         depth;
  } step_outcome_t;

  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  step_outcome_t      outcome_q[$];
  logic signed [31:0] operand_stack [STACK_DEPTH];
  int unsigned        stack_count = 0;
  logic [2:0]         step_status;
  int                 mismatch_cnt = 0;

  function automatic void flag_error(logic [2:0] code);
    if (step_status == rsc_pkg::ST_OK) step_status = code;
  endfunction

  function automatic void stack_push(logic signed [31:0] v);
    if (stack_count < STACK_DEPTH) begin
      operand_stack[stack_count] = v;
      stack_count++;
    end else begin
      flag_error(rsc_pkg::ST_FULL);
    end
  endfunction

  function automatic logic signed [31:0] stack_pop();
    if (stack_count > 0) begin
      stack_count--;
      return operand_stack[stack_count];
    end
    flag_error(rsc_pkg::ST_EMPTY);
    return '0;
  endfunction

  function automatic logic signed [31:0] saturate(longint v);
    if (v > longint'(Q_MAX)) return Q_MAX;
    if (v < longint'(Q_MIN)) return Q_MIN;
    return v[31:0];
  endfunction

  function automatic longint unsigned magnitude(logic signed [31:0] v);
    longint wide;
    wide = v;
    return (wide < 0) ? -wide : wide;
  endfunction

  function automatic logic signed [31:0] signed_clamp(longint unsigned m, bit neg);
    longint unsigned lim;
    lim = 64'h8000_0000;
    if (m > lim) m = lim;
    return saturate(neg ? -longint'(m) : longint'(m));
  endfunction

  function automatic logic signed [31:0] q_mul(logic signed [31:0] a, logic signed [31:0] b);
    return signed_clamp((magnitude(a) * magnitude(b)) >> 16, (a < 0) != (b < 0));
  endfunction

  function automatic logic signed [31:0] q_div(logic signed [31:0] a, logic signed [31:0] b);
    return signed_clamp((magnitude(a) << 16) / magnitude(b), (a < 0) != (b < 0));
  endfunction

  function automatic step_outcome_t rpn_evaluate(logic [3:0] op, logic signed [31:0] v);
    step_outcome_t      res;
    logic signed [31:0] a;
    logic signed [31:0] b;
    res = '0;
    step_status = rsc_pkg::ST_OK;
    case (op)
      rsc_pkg::OP_PUSH: stack_push(v);
      rsc_pkg::OP_ADD: begin
        b = stack_pop();
        a = stack_pop();
        stack_push(saturate(longint'(a) + longint'(b)));
      end
      rsc_pkg::OP_SUB: begin
        b = stack_pop();
        a = stack_pop();
        stack_push(saturate(longint'(a) - longint'(b)));
      end
      rsc_pkg::OP_MUL: begin
        b = stack_pop();
        a = stack_pop();
        stack_push(q_mul(a, b));
      end
      rsc_pkg::OP_DIV: begin
        b = stack_pop();
        if (b != 0) begin
          a = stack_pop();
          stack_push(q_div(a, b));
        end else begin
          flag_error(rsc_pkg::ST_ZDIV);
        end
      end
      rsc_pkg::OP_PEEK: begin
        if (stack_count > 0) begin
          res.value = operand_stack[stack_count - 1];
          res.shown = 1'b1;
        end else begin
          flag_error(rsc_pkg::ST_EMPTY);
        end
      end
      rsc_pkg::OP_DUP: begin
        if (stack_count > 0) begin
          a = stack_pop();
          stack_push(a);
          stack_push(a);
        end else begin
          flag_error(rsc_pkg::ST_EMPTY);
        end
      end
      rsc_pkg::OP_SWAP: begin
        if (stack_count > 1) begin
          a = stack_pop();
          b = stack_pop();
          stack_push(a);
          stack_push(b);
        end else begin
          flag_error(rsc_pkg::ST_SWAP);
        end
      end
      rsc_pkg::OP_CLEAR: stack_count = 0;
      rsc_pkg::OP_POP: begin
        res.value = stack_pop();
        res.shown = 1'b1;
      end
      default: ;
    endcase
    res.status = step_status;
    res.depth  = stack_count[7:0];
    return res;
  endfunction

  always @(posedge clk) begin
    step_outcome_t want;
    step_outcome_t seen;
    if (!rst_n) begin
      outcome_q.delete();
      stack_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        seen = '{value: out_result_value, shown: out_shown, status: out_status,
                 depth: out_depth_after};
        if (outcome_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("rsc_checker: unexpected transaction got %h/%0d/%0d/%0d",
                     seen.value, seen.shown, seen.status, seen.depth);
        end else begin
          want = outcome_q.pop_front();
          if (seen.value !== want.value || seen.shown !== want.shown ||
              seen.status !== want.status || seen.depth !== want.depth) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("rsc_checker: mismatch exp %h/%0d/%0d/%0d got %h/%0d/%0d/%0d",
                       want.value, want.shown, want.status, want.depth,
                       seen.value, seen.shown, seen.status, seen.depth);
          end
        end
      end
      if (in_valid && !in_stall) outcome_q.push_back(rpn_evaluate(in_op, in_value));
    end
    n_errors  <= mismatch_cnt;
    n_pending <= outcome_q.size();
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int          CYCLE_LIMIT  = 400000;
  localparam logic [3:0]  OP_UNUSED_LO = 4'hA;
  localparam logic [3:0]  OP_UNUSED_HI = 4'hF;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [3:0]         in_op = rsc_pkg::OP_PUSH;
  logic signed [31:0] in_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_result_value;
  logic               out_shown;
  logic [2:0]         out_status;
  logic [7:0]         out_depth_after;

  int          n_errors;
  int          n_pending;
  int unsigned cycles = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          sent = 0;

  logic [3:0] arith_ops [4] = '{rsc_pkg::OP_ADD, rsc_pkg::OP_SUB,
                                rsc_pkg::OP_MUL, rsc_pkg::OP_DIV};
  logic [3:0] misc_ops [4] = '{rsc_pkg::OP_PEEK, rsc_pkg::OP_DUP,
                               rsc_pkg::OP_SWAP, rsc_pkg::OP_POP};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  rpn_stack_calculator_core #(
    .STACK_DEPTH(rsc_pkg::STACK_DEPTH_DEF)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_op(in_op),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_result_value(out_result_value),
    .out_shown(out_shown),
    .out_status(out_status),
    .out_depth_after(out_depth_after)
  );

  rsc_checker #(
    .STACK_DEPTH(rsc_pkg::STACK_DEPTH_DEF)
  ) u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_op(in_op),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_result_value(out_result_value),
    .out_shown(out_shown),
    .out_status(out_status),
    .out_depth_after(out_depth_after),
    .n_errors(n_errors),
    .n_pending(n_pending)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  function automatic logic signed [31:0] pick_value();
    int unsigned sel;
    logic [19:0] mid;
    logic [18:0] low;
    sel = $urandom_range(99);
    mid = 20'($urandom);
    low = 19'($urandom);
    if (sel < 15) begin
      case ($urandom_range(6))
        0: return 32'sh7fff_ffff;
        1: return 32'sh8000_0000;
        2: return '0;
        3: return 32'sh0001_0000;
        4: return 32'shffff_0000;
        5: return 32'sh0000_0001;
        default: return 32'shffff_ffff;
      endcase
    end
    if (sel < 45) return $urandom;
    if (sel < 75) return {{12{mid[19]}}, mid};
    return {{13{low[18]}}, low};
  endfunction

  task automatic send_item(logic [3:0] op, logic signed [31:0] v);
    int   gap;
    logic go;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_value <= v;
    do begin
      @(negedge clk);
      go = !in_stall;
      @(posedge clk);
    end while (!go);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    wait (n_pending == 0);
    @(posedge clk);
  endtask

  task automatic fill_stack();
    repeat (rsc_pkg::STACK_DEPTH_DEF + 2) send_item(rsc_pkg::OP_PUSH, pick_value());
    send_item(rsc_pkg::OP_DUP, $urandom);
    send_item(rsc_pkg::OP_PEEK, $urandom);
    send_item(rsc_pkg::OP_SWAP, $urandom);
    send_item(rsc_pkg::OP_POP, $urandom);
    send_item(rsc_pkg::OP_MUL, $urandom);
    send_item(rsc_pkg::OP_DIV, $urandom);
    send_item(rsc_pkg::OP_ADD, $urandom);
    send_item(rsc_pkg::OP_CLEAR, $urandom);
  endtask

  task automatic run_episode();
    int unsigned kind;
    int unsigned k;
    kind = $urandom_range(99);
    if (kind < 60) begin
      k = $urandom_range(1, 4);
      repeat (k) send_item(rsc_pkg::OP_PUSH, pick_value());
      repeat ($urandom_range(k)) send_item(arith_ops[2'($urandom_range(3))], $urandom);
      if ($urandom_range(3) == 0) send_item(misc_ops[2'($urandom_range(3))], $urandom);
    end else if (kind < 75) begin
      send_item(4'($urandom_range(15)), $urandom);
    end else if (kind < 87) begin
      send_item(misc_ops[2'($urandom_range(3))], $urandom);
    end else if (kind < 91) begin
      send_item(rsc_pkg::OP_CLEAR, $urandom);
    end else begin
      send_item(rsc_pkg::OP_PUSH, pick_value());
      send_item(rsc_pkg::OP_DUP, $urandom);
      send_item(arith_ops[2'($urandom_range(3))], $urandom);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // empty stack cases
    send_item(rsc_pkg::OP_ADD, '0);
    send_item(rsc_pkg::OP_CLEAR, '0);
    send_item(rsc_pkg::OP_PEEK, '0);
    send_item(rsc_pkg::OP_POP, '0);
    send_item(rsc_pkg::OP_DUP, '0);
    send_item(rsc_pkg::OP_SWAP, '0);
    send_item(rsc_pkg::OP_DIV, '0);
    // saturation, zero divisor, swap, peek, dup, pop, clear and unused opcodes
    send_item(rsc_pkg::OP_PUSH, 32'sh7fff_ffff);
    send_item(rsc_pkg::OP_SWAP, '1);
    send_item(rsc_pkg::OP_PEEK, '0);
    send_item(rsc_pkg::OP_DUP, '0);
    send_item(rsc_pkg::OP_ADD, '0);
    send_item(rsc_pkg::OP_PUSH, 32'sh8000_0000);
    send_item(rsc_pkg::OP_SUB, '0);
    send_item(rsc_pkg::OP_PUSH, 32'sh8000_0000);
    send_item(rsc_pkg::OP_MUL, '0);
    send_item(rsc_pkg::OP_PUSH, '0);
    send_item(rsc_pkg::OP_DIV, '0);
    send_item(rsc_pkg::OP_PUSH, 32'shffff_0000);
    send_item(rsc_pkg::OP_DIV, '0);
    send_item(rsc_pkg::OP_PUSH, 32'sh0003_0000);
    send_item(rsc_pkg::OP_SWAP, '0);
    send_item(rsc_pkg::OP_DIV, '0);
    send_item(rsc_pkg::OP_POP, '0);
    send_item(rsc_pkg::OP_CLEAR, '1);
    send_item(OP_UNUSED_HI, '1);
    send_item(OP_UNUSED_LO, '0);

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 55;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 55;
        end
        default: begin
          idle_pct  = 21;
          stall_pct = 21;
        end
      endcase
      if (ph == 1 || ph == 3) fill_stack();
      while (sent < 27 + 150 * (ph + 1)) run_episode();
    end

    drain();
    repeat (60) @(posedge clk);
    if (n_errors == 0 && n_pending == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/rsc_pkg.sv
sv/rsc_stack_mem.sv
sv/rsc_arith.sv
sv/rpn_stack_calculator_core.sv
sv/rsc_checker.sv
tb/sv/rsc_checker.sv
tb/sv/tb_top.sv
